// ----- rtl/dnsq_pkg.sv -----
// Package for the DNS query name encoder: job descriptor, step codes,
// result kinds and the constant bytes of the query trailer and header.
// No dependencies.
`default_nettype none

package dnsq_pkg;

    // Field widths
    localparam int ADDR_W  = 9;
    localparam int COUNT_W = 6;
    localparam int STEP_W  = 5;

    // Defaults for the top-level parameters
    localparam int LABEL_LIMIT_DEF = 63;
    localparam int NAME_LIMIT_DEF  = 255;

    localparam logic [ADDR_W-1:0] HEADER_BYTES = 9'd12;
    localparam logic [7:0]        DOT_CHAR     = 8'd46;

    // Result kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Output sequencer steps: character write, slot write, five trailer
    // bytes, twelve header bytes, status
    localparam logic [STEP_W-1:0] STEP_CHAR   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_SLOT   = 5'd1;
    localparam logic [STEP_W-1:0] STEP_TAIL0  = 5'd2;
    localparam logic [STEP_W-1:0] STEP_HDR0   = 5'd7;
    localparam logic [STEP_W-1:0] STEP_STATUS = 5'd19;

    // Work handed from the label unit to the output sequencer
    typedef struct packed {
        logic              has_a;   // first byte write present
        logic              has_b;   // second byte write present
        logic [ADDR_W-1:0] a_addr;
        logic [7:0]        a_byte;
        logic [ADDR_W-1:0] b_addr;
        logic [7:0]        b_byte;
        logic              fin;     // last character: trailer, header, status
        logic              rej;     // name rejected
        logic [ADDR_W-1:0] tail;    // address of the zero terminator
        logic [15:0]       id;
    } dnsq_job_t;

    // Terminator, type A, class IN
    function automatic logic [7:0] tail_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd2:    b = 8'h01;
            3'd4:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Header: id, flags with RD set, one question, other counts zero
    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
        logic [7:0] b;
        case (idx)
            4'd0:    b = id[15:8];
            4'd1:    b = id[7:0];
            4'd2:    b = 8'h01;
            4'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dnsq_label_unit.sv -----
// Label tracking for the DNS query encoder: write position, length slot,
// label count and reject flag; forms at most one job per accepted character.
// Depends on dnsq_pkg.
`default_nettype none

module dnsq_label_unit
    import dnsq_pkg::*;
#(
    parameter int LABEL_LIMIT = LABEL_LIMIT_DEF,
    parameter int NAME_LIMIT  = NAME_LIMIT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  character,
    input  wire logic        final_char,
    input  wire logic [15:0] query_id,
    output dnsq_job_t        job,
    output logic             job_load
);

    localparam logic [COUNT_W-1:0] LABEL_MAX = COUNT_W'(LABEL_LIMIT);
    localparam logic [ADDR_W-1:0]  POS_MAX   = ADDR_W'(NAME_LIMIT + 10);

    logic [ADDR_W-1:0]  wpos_reg, wpos_next;
    logic [ADDR_W-1:0]  slot_reg, slot_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               rej_reg, rej_next;
    logic [ADDR_W-1:0]  wpos_inc;
    logic [COUNT_W-1:0] count_inc;

    assign wpos_inc  = wpos_reg + 1'b1;
    assign count_inc = count_reg + 1'b1;

    // Per-character state update and job formation
    always_comb
    begin
        wpos_next  = wpos_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        rej_next   = rej_reg;
        job        = '0;
        job.id     = query_id;
        job.fin    = final_char;
        if (!rej_reg)
        begin
            if (character == DOT_CHAR)
            begin
                if (count_reg == '0)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    job.has_a  = 1'b1;
                    job.a_addr = slot_reg;
                    job.a_byte = {2'b00, count_reg};
                    if (!final_char)
                    begin
                        wpos_next  = wpos_inc;
                        slot_next  = wpos_inc;
                        count_next = '0;
                    end
                end
            end
            else if (count_reg >= LABEL_MAX || wpos_reg >= POS_MAX)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                wpos_next  = wpos_inc;
                count_next = count_inc;
                job.has_a  = 1'b1;
                job.a_addr = wpos_inc;
                job.a_byte = character;
                job.has_b  = final_char;
                job.b_addr = slot_reg;
                job.b_byte = {2'b00, count_inc};
            end
        end
        job.rej  = rej_next;
        job.tail = wpos_next + 1'b1;
        // Name done: back to the empty state
        if (final_char)
        begin
            wpos_next  = HEADER_BYTES;
            slot_next  = HEADER_BYTES;
            count_next = '0;
            rej_next   = 1'b0;
        end
    end

    assign job_load = accept && (job.has_a || final_char);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg  <= HEADER_BYTES;
            slot_reg  <= HEADER_BYTES;
            count_reg <= '0;
            rej_reg   <= 1'b0;
        end
        else if (accept)
        begin
            wpos_reg  <= wpos_next;
            slot_reg  <= slot_next;
            count_reg <= count_next;
            rej_reg   <= rej_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dnsq_emit_seq.sv -----
// Output sequencer for the DNS query encoder: holds one job and steps
// through its writes and any status, one per cycle unless stalled.
// Depends on dnsq_pkg.
`default_nettype none

module dnsq_emit_seq
    import dnsq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_load,
    input  wire dnsq_job_t         job,
    output logic                   idle_next,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic [1:0]             kind,
    output logic [ADDR_W-1:0]      buffer_address,
    output logic [7:0]             byte_value,
    output logic [ADDR_W-1:0]      query_length,
    output logic                   run_end
);

    dnsq_job_t         job_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [STEP_W-1:0] step_inc;
    logic [STEP_W-1:0] step_after;
    logic              step_last;
    logic [STEP_W-1:0] tail_off;
    logic [STEP_W-1:0] hdr_off;

    assign step_inc = step_reg + 1'b1;
    assign tail_off = step_reg - STEP_TAIL0;
    assign hdr_off  = step_reg - STEP_HDR0;

    // Step that follows the current one
    always_comb
    begin
        step_after = step_inc;
        step_last  = 1'b0;
        case (step_reg)
            STEP_CHAR:
            begin
                if (job_reg.has_b)
                    step_after = STEP_SLOT;
                else if (job_reg.fin)
                    step_after = job_reg.rej ? STEP_STATUS : STEP_TAIL0;
                else
                    step_last = 1'b1;
            end
            STEP_SLOT:
            begin
                if (job_reg.fin)
                    step_after = job_reg.rej ? STEP_STATUS : STEP_TAIL0;
                else
                    step_last = 1'b1;
            end
            STEP_STATUS:
            begin
                step_last = 1'b1;
            end
            default:
            begin
                step_after = step_inc;
            end
        endcase
    end

    // Free now, or the last result of the job leaves this cycle
    assign idle_next = !busy_reg || (step_last && result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_CHAR;
        end
        else if (job_load)
        begin
            busy_reg <= 1'b1;
            step_reg <= job.has_a ? STEP_CHAR : STEP_STATUS;
        end
        else if (busy_reg && result_ready)
        begin
            if (step_last)
                busy_reg <= 1'b0;
            else
                step_reg <= step_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= job;
    end

    // Result fields for the current step
    always_comb
    begin
        kind           = KIND_WRITE;
        buffer_address = '0;
        byte_value     = '0;
        query_length   = '0;
        run_end        = 1'b0;
        case (step_reg)
            STEP_CHAR:
            begin
                buffer_address = job_reg.a_addr;
                byte_value     = job_reg.a_byte;
            end
            STEP_SLOT:
            begin
                buffer_address = job_reg.b_addr;
                byte_value     = job_reg.b_byte;
            end
            STEP_STATUS:
            begin
                run_end = 1'b1;
                if (job_reg.rej)
                begin
                    kind = KIND_REJECT;
                end
                else
                begin
                    kind         = KIND_DONE;
                    query_length = job_reg.tail + ADDR_W'(5);
                end
            end
            default:
            begin
                if (step_reg < STEP_HDR0)
                begin
                    buffer_address = job_reg.tail + {{(ADDR_W-STEP_W){1'b0}}, tail_off};
                    byte_value     = tail_byte(tail_off[2:0]);
                end
                else
                begin
                    buffer_address = {{(ADDR_W-STEP_W){1'b0}}, hdr_off};
                    byte_value     = hdr_byte(hdr_off[3:0], job_reg.id);
                end
            end
        endcase
    end

    assign result_valid = busy_reg;

endmodule

`default_nettype wire

// ----- rtl/dns_name_query_encoder_unit.sv -----
// Top level of the DNS A-record query name encoder.
// Depends on dnsq_pkg, dnsq_label_unit and dnsq_emit_seq.
`default_nettype none

// Takes a host name one character per transaction and emits address-tagged
// byte writes that build a DNS A query in a buffer (header at 0..11, name
// from 12). Each character before the last gives one write, none once the
// name is rejected. The last character of a name gives up to 20 results
// (label write, length byte, terminator, type, class, twelve header bytes,
// status) on the single result port; the next character is taken in the
// cycle the last result of the previous one leaves. A rejected name ends
// with one status result of kind reject. All results leave one per cycle
// from the sequencer register while result_ready is high.
module dns_name_query_encoder_unit
    import dnsq_pkg::*;
#(
    parameter int LABEL_LIMIT = LABEL_LIMIT_DEF,
    parameter int NAME_LIMIT  = NAME_LIMIT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              char_valid,
    output logic                   char_ready,
    input  wire logic [7:0]        character,
    input  wire logic              final_char,
    input  wire logic [15:0]       query_id,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic [1:0]             kind,
    output logic [ADDR_W-1:0]      buffer_address,
    output logic [7:0]             byte_value,
    output logic [ADDR_W-1:0]      query_length,
    output logic                   run_end
);

    dnsq_job_t job;
    logic      job_load;
    logic      idle_next;
    logic      accept;

    assign char_ready = idle_next;
    assign accept     = char_valid && char_ready;

    dnsq_label_unit #(
        .LABEL_LIMIT (LABEL_LIMIT),
        .NAME_LIMIT  (NAME_LIMIT)
    ) u_label (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .character  (character),
        .final_char (final_char),
        .query_id   (query_id),
        .job        (job),
        .job_load   (job_load)
    );

    dnsq_emit_seq u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_load       (job_load),
        .job            (job),
        .idle_next      (idle_next),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .buffer_address (buffer_address),
        .byte_value     (byte_value),
        .query_length   (query_length),
        .run_end        (run_end)
    );

endmodule

`default_nettype wire

// ----- rtl/dnsq_checker.sv -----
// Port-level checks for the DNS query encoder, bound to the top level.
// Depends on dnsq_pkg.
`default_nettype none

module dnsq_checker
    import dnsq_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic [1:0]        kind,
    input wire logic [ADDR_W-1:0] buffer_address,
    input wire logic [7:0]        byte_value,
    input wire logic [ADDR_W-1:0] query_length,
    input wire logic              run_end
);

    // Stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(kind)
            && $stable(buffer_address) && $stable(byte_value)
            && $stable(query_length) && $stable(run_end))
        else $error("stalled result changed");

    // Only status results end a name
    a_end_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && run_end |-> kind == KIND_DONE || kind == KIND_REJECT)
        else $error("run_end on a byte write");

    // Byte writes carry no length and do not end a name
    a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_WRITE |-> !run_end && query_length == '0)
        else $error("byte write with status fields");

    // Reject status carries no write and no length
    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_REJECT |->
            buffer_address == '0 && byte_value == '0 && query_length == '0)
        else $error("reject status with payload");

    // Shortest query: header, one-character label, terminator, type, class
    a_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_DONE |-> query_length >= ADDR_W'(19))
        else $error("query length too short");

endmodule

bind dns_name_query_encoder_unit dnsq_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for dns_name_query_encoder_unit: drives host names one character per
// transaction and checks every byte write and status result against a predictor.
// Depends on dnsq_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb
    import dnsq_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
        logic [ADDR_W-1:0] len;
        logic              done;
    } query_result_t;

    // Predicts the buffer writes of each name and checks results in order
    class query_image_tracker;
        logic [ADDR_W-1:0]  wr_pos;
        logic [ADDR_W-1:0]  slot;
        logic [COUNT_W-1:0] lbl_cnt;
        bit                 rejected;
        query_result_t      due_results[$];
        int unsigned        mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            wr_pos   = HEADER_BYTES;
            slot     = HEADER_BYTES;
            lbl_cnt  = '0;
            rejected = 0;
        endfunction

        function void push_result(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                                  logic [7:0] value, logic [ADDR_W-1:0] len, logic done);
            query_result_t r;
            r.kind  = kind;
            r.addr  = addr;
            r.value = value;
            r.len   = len;
            r.done  = done;
            due_results.push_back(r);
        endfunction

        // Returns 1 unless the transaction is dropped by an already rejected name
        function bit take_char(logic [7:0] ch, logic fin, logic [15:0] id);
            logic [ADDR_W-1:0] term;
            logic [7:0]        trailer[5];
            logic [7:0]        header[12];
            bit                used;
            used = !rejected || fin;
            if (!rejected) begin
                if (ch == DOT_CHAR) begin
                    // dot closes the label: length goes back into its slot
                    if (lbl_cnt == 0)
                        rejected = 1;
                    else begin
                        push_result(KIND_WRITE, slot, {2'b00, lbl_cnt}, '0, 1'b0);
                        if (!fin) begin
                            wr_pos  = wr_pos + 1'b1;
                            slot    = wr_pos;
                            lbl_cnt = '0;
                        end
                    end
                end else if (lbl_cnt >= LABEL_LIMIT_DEF || wr_pos >= NAME_LIMIT_DEF + 10) begin
                    rejected = 1;
                end else begin
                    wr_pos  = wr_pos + 1'b1;
                    push_result(KIND_WRITE, wr_pos, ch, '0, 1'b0);
                    lbl_cnt = lbl_cnt + 1'b1;
                    if (fin)
                        push_result(KIND_WRITE, slot, {2'b00, lbl_cnt}, '0, 1'b0);
                end
            end
            if (fin) begin
                if (rejected)
                    push_result(KIND_REJECT, '0, '0, '0, 1'b1);
                else begin
                    // terminator, type A, class IN
                    term    = wr_pos + 1'b1;
                    trailer = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h01};
                    for (int i = 0; i < 5; i++)
                        push_result(KIND_WRITE, term + ADDR_W'(i), trailer[i], '0, 1'b0);
                    // id, RD flag, one question, zero counts
                    header = '{id[15:8], id[7:0], 8'h01, 8'h00, 8'h00, 8'h01,
                               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
                    for (int i = 0; i < 12; i++)
                        push_result(KIND_WRITE, ADDR_W'(i), header[i], '0, 1'b0);
                    push_result(KIND_DONE, '0, '0, term + 9'd5, 1'b1);
                end
                clear();
            end
            return used;
        endfunction

        function void match_result(query_result_t got);
            query_result_t want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR %0t: unexpected result %s",
                             $realtime,
                             $sformatf("kind=%0d addr=%0d byte=%02h len=%0d end=%0d",
                                       got.kind, got.addr, got.value, got.len,
                                       got.done));
                return;
            end
            want = due_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR %0t: expected %s, got %s",
                             $realtime,
                             $sformatf("kind=%0d addr=%0d byte=%02h len=%0d end=%0d",
                                       want.kind, want.addr, want.value, want.len,
                                       want.done),
                             $sformatf("kind=%0d addr=%0d byte=%02h len=%0d end=%0d",
                                       got.kind, got.addr, got.value, got.len,
                                       got.done));
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              char_valid;
    logic              char_ready;
    logic [7:0]        character;
    logic              final_char;
    logic [15:0]       query_id;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] buffer_address;
    logic [7:0]        byte_value;
    logic [ADDR_W-1:0] query_length;
    logic              run_end;

    query_image_tracker tracker;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 live_items;
    int                 cycles = 0;

    dns_name_query_encoder_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_ready     (char_ready),
        .character      (character),
        .final_char     (final_char),
        .query_id       (query_id),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .buffer_address (buffer_address),
        .byte_value     (byte_value),
        .query_length   (query_length),
        .run_end        (run_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Receiver back-pressure
    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checking on accepted transactions
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.match_result({kind, buffer_address, byte_value, query_length, run_end});
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_label_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == DOT_CHAR);
        return c;
    endfunction

    // One character transaction, with random sender gaps
    task automatic send_char(input logic [7:0] ch, input logic fin, input logic [15:0] id);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        character  <= ch;
        final_char <= fin;
        query_id   <= id;
        do
            @(posedge clk);
        while (!char_ready);
        if (tracker.take_char(ch, fin, id))
            live_items++;
    endtask

    task automatic send_text(input string s, input logic [15:0] id);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1, id);
    endtask

    task automatic send_label(input int len, input bit fin);
        for (int i = 0; i < len; i++)
            send_char(rand_label_char(), fin && (i == len - 1), 16'($urandom));
    endtask

    task automatic send_dot(input bit fin);
        send_char(DOT_CHAR, fin, 16'($urandom));
    endtask

    // Hold the sender until every predicted result has left the block
    task automatic wait_drained();
        @(negedge clk);
        char_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_name();
        int  n_lbl;
        int  len;
        int  r;
        bit  dot_end;
        if ($urandom_range(99) < 15) begin
            // noise: short runs with dots anywhere
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_char(($urandom_range(99) < 30) ? DOT_CHAR : rand_label_char(),
                          i == len - 1, 16'($urandom));
        end else begin
            n_lbl   = $urandom_range(1, 4);
            dot_end = ($urandom_range(99) < 20);
            for (int l = 0; l < n_lbl; l++) begin
                r = $urandom_range(99);
                if (r < 5)
                    len = 0;
                else if (r < 10)
                    len = $urandom_range(20, 63);
                else
                    len = $urandom_range(1, 10);
                if (l != n_lbl - 1) begin
                    send_label(len, 0);
                    send_dot(0);
                end else if (dot_end || len == 0) begin
                    send_label(len, 0);
                    send_dot(1);
                end else
                    send_label(len, 1);
            end
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
        int start;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start          = live_items;
        while (live_items - start < count)
            send_random_name();
        wait_drained();
    endtask

    initial
    begin
        tracker        = new();
        rst_n          = 1'b0;
        char_valid     = 1'b0;
        character      = '0;
        final_char     = 1'b0;
        query_id       = '0;
        send_idle_pct  = 20;
        recv_stall_pct = 56;
        live_items     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, dots, rejections, zero character
        send_char(8'd1, 1'b1, 16'h0000);
        send_char(8'hFF, 1'b1, 16'hFFFF);
        send_text("ab.c", 16'hA5C3);
        send_text("x.", 16'h5A3C);
        send_text(".", 16'h1234);
        send_text(".a", 16'h8001);
        send_text("a..b", 16'h00FF);
        send_char(8'd0, 1'b0, 16'h0F0F);
        send_char("z", 1'b1, 16'hF0F0);
        send_text("q.r.", 16'h7FFE);
        wait_drained();

        // Random names under three idle regimes; one label that fills up and overflows
        run_random_phase(20, 56, 7);
        send_label(LABEL_LIMIT_DEF + 1, 1);
        run_random_phase(56, 20, 7);
        run_random_phase(0, 0, 6);

        wait_drained();
        repeat (30) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dnsq_pkg.sv
rtl/dnsq_label_unit.sv
rtl/dnsq_emit_seq.sv
rtl/dns_name_query_encoder_unit.sv
rtl/dnsq_checker.sv
tb/tb.sv
